@@ rtl/core/quaternion_to_euler_angles_core_assert.svh @@
// Assertion macros for the quaternion to Euler angle core.
// Used by quaternion_to_euler_angles_core; no other dependencies.
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_ASSERT_SVH

// assertion checked on every clock edge outside reset
`define Q2E_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// assertion that also holds during reset
`define Q2E_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/q2e_pkg.sv @@
// Shared types, constants and the arctangent table for the Euler angle core.
// No dependencies.
`timescale 1ns / 1ps
package q2e_pkg;
   localparam int CordicStagesDefault = 16;
   localparam int AtanEntries = 24;
   // datapath widths, units of 2^-30
   localparam int VW = 36;  // vector components
   localparam int ZW = 33;  // angle accumulator
   localparam logic signed [ZW-1:0] HalfPiQ30 = 33'sd1686629713;
   localparam logic signed [ZW-1:0] OneQ30 = 33'sd1073741824;
   localparam int RollYawLimit = 23100;
   localparam int PitchLimit = 11550;

   typedef struct packed {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_vec_type;

   function automatic logic signed [ZW-1:0] atan_lut(input int idx);
      logic signed [ZW-1:0] r;
      case (idx)
         0: r = 33'sd843314857;
         1: r = 33'sd497837829;
         2: r = 33'sd263043837;
         3: r = 33'sd133525159;
         4: r = 33'sd67021687;
         5: r = 33'sd33543516;
         6: r = 33'sd16775851;
         7: r = 33'sd8388437;
         8: r = 33'sd4194283;
         9: r = 33'sd2097149;
         10: r = 33'sd1048576;
         11: r = 33'sd524288;
         12: r = 33'sd262144;
         13: r = 33'sd131072;
         14: r = 33'sd65536;
         15: r = 33'sd32768;
         16: r = 33'sd16384;
         17: r = 33'sd8192;
         18: r = 33'sd4096;
         19: r = 33'sd2048;
         20: r = 33'sd1024;
         21: r = 33'sd512;
         22: r = 33'sd256;
         23: r = 33'sd128;
         default: r = '0;
      endcase
      return r;
   endfunction
endpackage

@@ rtl/core/q2e_sqrt_cell.sv @@
// One restoring square root step: produces one result bit per cell.
// No package dependencies.
`timescale 1ns / 1ps
module q2e_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic        clock,
   input  logic        en,
   input  logic [61:0] rem_in,
   input  logic [30:0] root_in,
   output logic [61:0] rem_out,
   output logic [30:0] root_out
);
   // bit weight under test is 2^(30-STEP) in the root
   localparam int BIT = 30 - STEP;
   logic [62:0] trial;
   logic [61:0] rem_in_c;
   logic [30:0] root_in_c;
   always_comb begin
      trial = (63'(root_in) << (BIT + 1)) | (63'd1 << (2 * BIT));
      if ({1'b0, rem_in} >= trial) begin
         rem_in_c = rem_in - trial[61:0];
         root_in_c = root_in | (31'd1 << BIT);
      end else begin
         rem_in_c = rem_in;
         root_in_c = root_in;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rem_out <= rem_in_c;
         root_out <= root_in_c;
      end
   end
endmodule

@@ rtl/core/q2e_cordic_cell.sv @@
// One vectoring CORDIC rotation stage with a register on its output.
// Depends on q2e_pkg for the vector type and arctangent table.
`timescale 1ns / 1ps
module q2e_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                    clock,
   input  logic                    en,
   input  q2e_pkg::cordic_vec_type vec_in,
   output q2e_pkg::cordic_vec_type vec_out
);
   import q2e_pkg::*;
   cordic_vec_type nxt;
   logic signed [VW-1:0] dx, dy;
   always_comb begin
      dx = vec_in.y >>> STEP;
      dy = vec_in.x >>> STEP;
      nxt = vec_in;
      if (STEP < AtanEntries) begin
         if (!vec_in.y[VW-1]) begin
            nxt.x = vec_in.x + dx;
            nxt.y = vec_in.y - dy;
            nxt.z = vec_in.z + atan_lut(STEP);
         end else begin
            nxt.x = vec_in.x - dx;
            nxt.y = vec_in.y + dy;
            nxt.z = vec_in.z - atan_lut(STEP);
         end
      end
   end
   always_ff @(posedge clock) begin
      if (en) vec_out <= nxt;
   end
endmodule

@@ rtl/core/q2e_deg_conv.sv @@
// Radians (2^-30 units) to degrees Q8.7, nearest with ties away, saturated.
// Depends on q2e_pkg. Two register stages.
`timescale 1ns / 1ps
module q2e_deg_conv #(
   parameter int LIMIT = q2e_pkg::RollYawLimit
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [q2e_pkg::ZW-1:0] rad,
   output logic signed [15:0]          deg
);
   import q2e_pkg::*;
   // den = 31415 << 23; q = (|rad|*1800000 + den/2) / den
   localparam longint Den = 64'd31415 << 23;
   // q = floor((num >> 23) / 31415) by reciprocal multiplication, exact below 2^30
   localparam logic [30:0] RecipMul = 31'd1119986379;
   localparam int RecipShift = 45;
   logic [31:0] mag_c;
   logic [52:0] prod_ff;
   logic        neg_ff;
   logic [29:0] num_c;
   logic [60:0] recip_c;
   logic [15:0] q_c;
   logic [15:0] clip_c;
   always_comb mag_c = rad[ZW-1] ? 32'(-rad) : 32'(rad);
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= 53'(mag_c) * 53'd1800000 + 53'(Den / 2);
         neg_ff <= rad[ZW-1];
      end
   end
   always_comb begin
      num_c = prod_ff[52:23];
      recip_c = num_c * RecipMul;
      q_c = recip_c[RecipShift+15:RecipShift];
      clip_c = (q_c > 16'(LIMIT)) ? 16'(LIMIT) : q_c;
   end
   always_ff @(posedge clock) begin
      if (en) deg <= neg_ff ? -clip_c : clip_c;
   end
endmodule

@@ rtl/core/quaternion_to_euler_angles_core.sv @@
// Quaternion to ZYX Euler angles: one transaction accepted per cycle while
// the skid register is empty. The CORDIC chain follows a 31-cell square
// root chain and a product stage; a result the stalled output cannot take
// waits in a skid register; the pipeline stalls while it is full. Synchronous
// active-high reset clears valid bits; payload registers are not reset.
// Depends on q2e_pkg and the cell modules.
`timescale 1ns / 1ps
module quaternion_to_euler_angles_core #(
   parameter int CORDIC_STAGES = q2e_pkg::CordicStagesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // quat_w, quat_x, quat_y, quat_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // roll_deg, pitch_deg, yaw_deg, pad bit
   output logic        rsp_tuser   // pitch_clamped
);
   import q2e_pkg::*;
   `include "quaternion_to_euler_angles_core_assert.svh"

   localparam int SQ = 31;
   localparam int LAT = 1 + SQ + 1 + CORDIC_STAGES + 2;

   logic en;
   logic [LAT-1:0] vld_ff;
   // skid
   logic        skid_vld_ff;
   logic [47:0] skid_data_ff;
   logic        skid_user_ff;
   logic        out_vld_ff;
   logic [47:0] out_data_ff;
   logic        out_user_ff;

   // pipeline moves unless the skid register is full
   assign en = !skid_vld_ff;
   assign req_tready = en;

   // stage 0: products
   logic signed [15:0] w, x, y, z;
   assign w = req_tdata[15:0];
   assign x = req_tdata[31:16];
   assign y = req_tdata[47:32];
   assign z = req_tdata[63:48];
   logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;
   assign p_wx = w * x;
   assign p_yz = y * z;
   assign p_xx = x * x;
   assign p_yy = y * y;
   assign p_wz = w * z;
   assign p_xy = x * y;
   assign p_zz = z * z;
   assign p_wy = w * y;
   assign p_zx = z * x;
   logic signed [VW-1:0] rn_ff, rd_ff, yn_ff, yd_ff, a_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         rn_ff <= (VW'(p_wx) + VW'(p_yz)) <<< 1;
         rd_ff <= VW'(OneQ30) - ((VW'(p_xx) + VW'(p_yy)) <<< 1);
         yn_ff <= (VW'(p_wz) + VW'(p_xy)) <<< 1;
         yd_ff <= VW'(OneQ30) - ((VW'(p_yy) + VW'(p_zz)) <<< 1);
         a_ff <= (VW'(p_wy) - VW'(p_zx)) <<< 1;
      end
   end

   // clamp and start square root chain
   logic signed [VW-1:0] ac;
   logic clamp;
   logic [30:0] ac_mag;
   logic [61:0] ac_sq;
   always_comb begin
      clamp = (a_ff > VW'(OneQ30)) || (a_ff < -VW'(OneQ30));
      ac = (a_ff > VW'(OneQ30)) ? VW'(OneQ30) :
           (a_ff < -VW'(OneQ30)) ? -VW'(OneQ30) : a_ff;
      ac_mag = ac[VW-1] ? 31'(-ac) : 31'(ac);
      ac_sq = ac_mag * ac_mag;
   end

   logic [61:0] rem [SQ+1];
   logic [30:0] root [SQ+1];
   assign rem[0] = (62'd1 << 60) - ac_sq;
   assign root[0] = '0;
   // carried operands through the root chain
   logic signed [VW-1:0] c_rn [SQ+1], c_rd [SQ+1], c_yn [SQ+1], c_yd [SQ+1], c_a [SQ+1];
   logic c_cl [SQ+1];
   assign c_rn[0] = rn_ff;
   assign c_rd[0] = rd_ff;
   assign c_yn[0] = yn_ff;
   assign c_yd[0] = yd_ff;
   assign c_a[0] = ac;
   assign c_cl[0] = clamp;

   for (genvar g = 0; g < SQ; g++) begin : g_sqrt
      q2e_sqrt_cell #(.STEP(g)) u_cell (
         .clock(clock), .en(en),
         .rem_in(rem[g]), .root_in(root[g]),
         .rem_out(rem[g+1]), .root_out(root[g+1])
      );
      always_ff @(posedge clock) begin
         if (en) begin
            c_rn[g+1] <= c_rn[g];
            c_rd[g+1] <= c_rd[g];
            c_yn[g+1] <= c_yn[g];
            c_yd[g+1] <= c_yd[g];
            c_a[g+1] <= c_a[g];
            c_cl[g+1] <= c_cl[g];
         end
      end
   end

   // pre-rotation into the right half-plane
   function automatic cordic_vec_type pre_rot(input logic signed [VW-1:0] yy,
                                              input logic signed [VW-1:0] xx);
      cordic_vec_type v;
      v.x = xx;
      v.y = yy;
      v.z = '0;
      if (xx[VW-1]) begin
         if (!yy[VW-1]) begin
            v.x = yy; v.y = -xx; v.z = HalfPiQ30;
         end else begin
            v.x = -yy; v.y = xx; v.z = -HalfPiQ30;
         end
      end
      return v;
   endfunction

   cordic_vec_type cr [CORDIC_STAGES+1];
   cordic_vec_type cp [CORDIC_STAGES+1];
   cordic_vec_type cy [CORDIC_STAGES+1];
   logic zr [CORDIC_STAGES+1], zy [CORDIC_STAGES+1];
   logic cl [CORDIC_STAGES+1];
   always_ff @(posedge clock) begin
      if (en) begin
         cr[0] <= pre_rot(c_rn[SQ], c_rd[SQ]);
         cp[0] <= pre_rot(c_a[SQ], VW'(root[SQ]));
         cy[0] <= pre_rot(c_yn[SQ], c_yd[SQ]);
         zr[0] <= (c_rn[SQ] == '0) && (c_rd[SQ] == '0);
         zy[0] <= (c_yn[SQ] == '0) && (c_yd[SQ] == '0);
         cl[0] <= c_cl[SQ];
      end
   end

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      q2e_cordic_cell #(.STEP(g)) u_r (.clock(clock), .en(en), .vec_in(cr[g]),
                                       .vec_out(cr[g+1]));
      q2e_cordic_cell #(.STEP(g)) u_p (.clock(clock), .en(en), .vec_in(cp[g]),
                                       .vec_out(cp[g+1]));
      q2e_cordic_cell #(.STEP(g)) u_y (.clock(clock), .en(en), .vec_in(cy[g]),
                                       .vec_out(cy[g+1]));
      always_ff @(posedge clock) begin
         if (en) begin
            zr[g+1] <= zr[g];
            zy[g+1] <= zy[g];
            cl[g+1] <= cl[g];
         end
      end
   end

   logic signed [15:0] roll_d, pitch_d, yaw_d;
   logic cl1_ff, cl2_ff;
   logic signed [ZW-1:0] roll_z, yaw_z;
   // exact zero vector gives zero angle
   assign roll_z = zr[CORDIC_STAGES] ? '0 : cr[CORDIC_STAGES].z;
   assign yaw_z = zy[CORDIC_STAGES] ? '0 : cy[CORDIC_STAGES].z;
   q2e_deg_conv #(.LIMIT(RollYawLimit)) u_dr (.clock(clock), .en(en),
      .rad(roll_z), .deg(roll_d));
   q2e_deg_conv #(.LIMIT(PitchLimit)) u_dp (.clock(clock), .en(en),
      .rad(cp[CORDIC_STAGES].z), .deg(pitch_d));
   q2e_deg_conv #(.LIMIT(RollYawLimit)) u_dy (.clock(clock), .en(en),
      .rad(yaw_z), .deg(yaw_d));
   always_ff @(posedge clock) begin
      if (en) begin
         cl1_ff <= cl[CORDIC_STAGES];
         cl2_ff <= cl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
   end

   logic [47:0] pipe_data;
   assign pipe_data = {1'b0, yaw_d, pitch_d[14:0], roll_d};
   logic pipe_vld;
   assign pipe_vld = vld_ff[LAT-1] && en;

   // output register with a skid stage behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (!out_vld_ff || rsp_tready) begin
            if (skid_vld_ff) begin
               out_vld_ff <= 1'b1;
               skid_vld_ff <= 1'b0;
            end else begin
               out_vld_ff <= pipe_vld;
            end
         end else if (pipe_vld) begin
            skid_vld_ff <= 1'b1;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (!out_vld_ff || rsp_tready) begin
         out_data_ff <= skid_vld_ff ? skid_data_ff : pipe_data;
         out_user_ff <= skid_vld_ff ? skid_user_ff : cl2_ff;
      end
      if (pipe_vld && out_vld_ff && !rsp_tready) begin
         skid_data_ff <= pipe_data;
         skid_user_ff <= cl2_ff;
      end
   end
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_user_ff;

   `Q2E_ASSERT(a_skid_needs_out, clock, reset, skid_vld_ff |-> out_vld_ff,
      "skid holds a transaction while output empty")
   `Q2E_ASSERT(a_stall_no_accept, clock, reset, skid_vld_ff |-> !req_tready,
      "input accepted while skid full")
   `Q2E_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_tvalid,
      "result valid right after reset")
endmodule
